// ===== rtl/min_bond_length_by_species_pair_unit_assert.svh =====
// assertion macros for the minimum bond length unit
// no dependencies; included by mblsp_ctrl, which checks its own logic
`ifndef MIN_BOND_LENGTH_BY_SPECIES_PAIR_UNIT_ASSERT_SVH
`define MIN_BOND_LENGTH_BY_SPECIES_PAIR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, masked while reset is low
`define MBL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mbl assertion failed");
// checked property that also watches the reset cycles
`define MBL_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mbl reset assertion failed");
`else
`define MBL_ASSERT(lbl, clk, rst_n, prop)
`define MBL_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/mblsp_pkg.sv =====
// shared types and constants of the minimum bond length unit
// no dependencies
package mblsp_pkg;

  localparam int POS_W   = 24;
  localparam int DIST_W  = 24;
  localparam int SQ_W    = 2 * DIST_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int SQRT_STEPS = DIST_W;

  localparam logic [DIST_W-1:0] CUTOFF_RESET = 24'd851968;
  localparam logic [SQ_W-1:0] CUTOFF_SQ_RESET =
    SQ_W'(CUTOFF_RESET) * SQ_W'(CUTOFF_RESET);

  localparam logic [1:0] SPECIES_AFE = 2'd1;
  localparam logic [1:0] SPECIES_DFE = 2'd2;
  localparam logic [1:0] SPECIES_O   = 2'd3;

  localparam logic [1:0] CLASS_AFE_O   = 2'd0;
  localparam logic [1:0] CLASS_DFE_O   = 2'd1;
  localparam logic [1:0] CLASS_AFE_DFE = 2'd2;
  localparam logic [1:0] CLASS_DFE_DFE = 2'd3;
  localparam int NUM_CLASSES = 4;

  typedef struct packed {
    logic [1:0]       species;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } atom_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic       init_min;
    logic       issue;
    logic       sqrt_start;
    logic       emit;
    logic       last_emit;
    logic [1:0] out_class;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic sqrt_done;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/mblsp_if.sv =====
// atom and bond channel interfaces with valid/ready handshake
// no dependencies
interface mblsp_atom_if;
  logic               valid;
  logic               ready;
  logic [1:0]         species_code;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic               is_last;

  modport source (output valid, species_code, pos_x, pos_y, pos_z, is_last,
                  input ready);
  modport sink (input valid, species_code, pos_x, pos_y, pos_z, is_last,
                output ready);
endinterface

interface mblsp_bond_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bond_class;
  logic [23:0] distance;
  logic        last_result;

  modport source (output valid, bond_class, distance, last_result, input ready);
  modport sink (input valid, bond_class, distance, last_result, output ready);
endinterface

// ===== rtl/mblsp_sqrt.sv =====
// floor square root, one result bit per cycle
// depends on mblsp_pkg
module mblsp_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mblsp_pkg::SQ_W-1:0]    radicand,
  output logic                          done,
  output logic [mblsp_pkg::DIST_W-1:0]  root
);
  import mblsp_pkg::*;

  localparam int CNT_W = $clog2(SQRT_STEPS);
  localparam int REM_W = DIST_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIST_W-1:0] root_r;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    fits   = rem_sh >= (REM_W+2)'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r + 1'b1;
      if (fits) begin
        rem_r  <= REM_W'(rem_sh - (REM_W+2)'(trial));
        root_r <= {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[DIST_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/mblsp_dp.sv =====
// datapath: atom memory, pair distance pipeline, class minima, sqrt, output register
// depends on mblsp_pkg and mblsp_sqrt
module mblsp_dp #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mblsp_pkg::DIST_W-1:0]    cfg_wdata,
  input  logic [1:0]                      in_species,
  input  logic signed [mblsp_pkg::POS_W-1:0] in_x,
  input  logic signed [mblsp_pkg::POS_W-1:0] in_y,
  input  logic signed [mblsp_pkg::POS_W-1:0] in_z,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_ATOMS)-1:0]    wr_addr,
  input  logic [$clog2(MAX_ATOMS)-1:0]    rd_addr_a,
  input  logic [$clog2(MAX_ATOMS)-1:0]    rd_addr_b,
  input  mblsp_pkg::ctl_cmd_t             cmd,
  output mblsp_pkg::ctl_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_bond_class,
  output logic [mblsp_pkg::DIST_W-1:0]    out_distance,
  output logic                            out_last_result
);
  import mblsp_pkg::*;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    d = {b[POS_W-1], b} - {a[POS_W-1], a};
    return d[POS_W] ? POS_W'(~d + 1'b1) : d[POS_W-1:0];
  endfunction

  // configuration, held as the squared bound so a search right after a write sees it
  logic [SQ_W-1:0]   cutoff_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_sq_r <= CUTOFF_SQ_RESET;
    end else if (cfg_we) begin
      cutoff_sq_r <= SQ_W'(cfg_wdata) * SQ_W'(cfg_wdata);
    end
  end

  // atom memory, one write and two registered reads
  atom_t mem [MAX_ATOMS];
  atom_t rd_a_r;
  atom_t rd_b_r;
  atom_t wr_word;

  assign wr_word = '{species: in_species, x: in_x, y: in_y, z: in_z};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // pair pipeline
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [1:0]        cls2_r, cls3_r, cls4_r;
  logic [POS_W-1:0]  adx_r, ady_r, adz_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]  sum_r;
  logic [1:0]        cls1;
  logic              cls1_ok;

  always_comb begin
    cls1    = CLASS_AFE_O;
    cls1_ok = 1'b1;
    priority if (rd_a_r.species == SPECIES_AFE && rd_b_r.species == SPECIES_O) begin
      cls1 = CLASS_AFE_O;
    end else if (rd_a_r.species == SPECIES_DFE && rd_b_r.species == SPECIES_O) begin
      cls1 = CLASS_DFE_O;
    end else if (rd_a_r.species == SPECIES_AFE && rd_b_r.species == SPECIES_DFE) begin
      cls1 = CLASS_AFE_DFE;
    end else if (rd_a_r.species == SPECIES_DFE && rd_b_r.species == SPECIES_DFE) begin
      cls1 = CLASS_DFE_DFE;
    end else begin
      cls1_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r && cls1_ok;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    adx_r  <= abs_diff(rd_a_r.x, rd_b_r.x);
    ady_r  <= abs_diff(rd_a_r.y, rd_b_r.y);
    adz_r  <= abs_diff(rd_a_r.z, rd_b_r.z);
    cls2_r <= cls1;
    sqx_r  <= adx_r * adx_r;
    sqy_r  <= ady_r * ady_r;
    sqz_r  <= adz_r * adz_r;
    cls3_r <= cls2_r;
    sum_r  <= SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
    cls4_r <= cls3_r;
  end

  // class minima; drained in class order by shifting toward entry zero
  logic [SQ_W-1:0] min_r [NUM_CLASSES];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cmd.init_min) begin
        min_r[c] <= cutoff_sq_r;
      end else if (cmd.emit) begin
        if (c < NUM_CLASSES - 1) min_r[c] <= min_r[(c + 1) % NUM_CLASSES];
      end else if (v4_r && cls4_r == 2'(c) && sum_r < SUM_W'(min_r[c])) begin
        min_r[c] <= sum_r[SQ_W-1:0];
      end
    end
  end

  // square root of the class at the head
  logic              sqrt_done;
  logic [DIST_W-1:0] sqrt_root;

  mblsp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (min_r[0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // output register
  logic              out_valid_r;
  logic [1:0]        out_class_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_class_r <= cmd.out_class;
      out_dist_r  <= sqrt_root;
      out_last_r  <= cmd.last_emit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bond_class  = out_class_r;
  assign out_distance    = out_dist_r;
  assign out_last_result = out_last_r;

  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/mblsp_ctrl.sv =====
// controller: atom loading, pair loop, sqrt and emit sequencing
// depends on mblsp_pkg and the assertion macro header
`include "min_bond_length_by_species_pair_unit_assert.svh"
module mblsp_ctrl #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_is_last,
  output logic                          in_ready,
  output logic                          wr_en,
  output logic [$clog2(MAX_ATOMS)-1:0]  wr_addr,
  output logic [$clog2(MAX_ATOMS)-1:0]  rd_addr_a,
  output logic [$clog2(MAX_ATOMS)-1:0]  rd_addr_b,
  output mblsp_pkg::ctl_cmd_t           cmd,
  input  mblsp_pkg::ctl_sts_t           sts
);
  import mblsp_pkg::*;

  localparam int IW = $clog2(MAX_ATOMS);
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ATOMS);

  ctl_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [CW-1:0] last_idx;

  assign last_idx  = count_r - 1'b1;
  assign wr_addr   = count_r[IW-1:0];
  assign rd_addr_a = i_r;
  assign rd_addr_b = j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    cmd           = '0;
    cmd.out_class = k_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // a full store drops the atom
          if (count_r < MAX_CNT) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_is_last) begin
            cmd.init_min = 1'b1;
            i_nxt        = '0;
            j_nxt        = '0;
            state_nxt    = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.issue = (i_r != j_r);
        if (CW'(j_r) == last_idx) begin
          j_nxt = '0;
          if (CW'(i_r) == last_idx) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          count_nxt = '0;
          k_nxt     = '0;
          state_nxt = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sts.sqrt_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.last_emit = (k_r == CLASS_DFE_DFE);
          if (k_r == CLASS_DFE_DFE) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_SQRT_GO;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  `MBL_ASSERT(a_done_only_waiting, clk, rst_n, sts.sqrt_done |-> state_r == ST_SQRT_WAIT)
  `MBL_ASSERT(a_pipe_empty_at_sqrt, clk, rst_n, state_r == ST_SQRT_GO |-> !sts.pipe_busy)
  `MBL_ASSERT(a_count_bound, clk, rst_n, count_r <= MAX_CNT)
  `MBL_ASSERT(a_last_emit_to_load, clk, rst_n, cmd.last_emit |=> state_r == ST_LOAD)
  `MBL_ASSERT_RST(a_reset_clears, clk, !rst_n |=> state_r == ST_LOAD && count_r == '0)

endmodule

// ===== rtl/min_bond_length_by_species_pair_unit.sv =====
// top level of the minimum bond length per species pair unit
// depends on mblsp_pkg, mblsp_if, mblsp_ctrl and mblsp_dp
//
// usage
//   in_atom carries one atom per item: species code and signed Q8.16 x, y, z.
//   atoms are taken one per cycle and written to the atom memory; an atom
//   that arrives with the memory full is dropped. the item with is_last set
//   closes the cell and starts the pair search, and no further item is taken
//   until the fourth result has been placed on out_bond.
//   out_bond then carries four items, classes aFe-O, dFe-O, aFe-dFe, dFe-dFe
//   in that order, each the floor square root of the class minimum, with
//   last_result set on the fourth. a class with no pair reports the cutoff.
//   cfg_we / cfg_wdata write the cutoff; the user must do so only while the
//   unit is idle, as the unit itself does not enforce it.
// sequence
//   after the last atom, with n atoms stored, the search visits n*n (i, j)
//   slots at one per cycle through the dual read memory, then drains the
//   distance pipeline; each class then runs the bit-serial square root
//   (24 steps) and is emitted.
// reset and stall
//   synchronous active-low reset empties the store, clears the output and
//   reloads the cutoff to 13.0. a stalled out_bond holds the current result;
//   the next square root may run behind it but is emitted only once taken.
module min_bond_length_by_species_pair_unit #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mblsp_pkg::DIST_W-1:0] cfg_wdata,
  mblsp_atom_if.sink                   in_atom,
  mblsp_bond_if.source                 out_bond
);
  import mblsp_pkg::*;

  localparam int IW = $clog2(MAX_ATOMS);

  // control to datapath link
  ctl_cmd_t      cmd;
  ctl_sts_t      sts;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr_a;
  logic [IW-1:0] rd_addr_b;

  // sequencer: load, pair loop, per-class sqrt and emit
  mblsp_ctrl #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_atom.valid),
    .in_is_last (in_atom.is_last),
    .in_ready   (in_atom.ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .cmd        (cmd),
    .sts        (sts)
  );

  // storage, distance pipeline, minima, square root and output register
  mblsp_dp #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_species      (in_atom.species_code),
    .in_x            (in_atom.pos_x),
    .in_y            (in_atom.pos_y),
    .in_z            (in_atom.pos_z),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_bond.valid),
    .out_ready       (out_bond.ready),
    .out_bond_class  (out_bond.bond_class),
    .out_distance    (out_bond.distance),
    .out_last_result (out_bond.last_result)
  );

endmodule
